FILE: rtl/tcpc_pkg.sv
// Shared types, widths and helpers for the triangle plane clipper.
// No dependencies; every other file of the block imports this package.
package tcpc_pkg;

    // Coordinate width taken from the low bits of each 32-bit field
    localparam int COORD_BITS = 32;
    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int FW = 32;                       // field width on the ports
    localparam int NW = 16;                       // normal component width
    localparam int FRAC_DROP = 14;                // Q.30 -> Q.16
    localparam int PW = NW + CW;                  // one normal * coordinate product
    localparam int SW = PW + 2;                   // sum of three products
    localparam int DW = (((SW - FRAC_DROP) > FW) ? (SW - FRAC_DROP) : FW) + 1;
    localparam int RW = DW + 1;                   // divisor / remainder width
    localparam int NLO = (DW + 1) / 2;            // low slice of the multiplier split
    localparam int NHI = DW - NLO;
    localparam int XW = CW + DW;                  // dividend width
    localparam int L_CUT = 3 + CW + 1;            // edge cut lane register stages

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W = 32;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X     = 2'd0,
        CFG_NORMAL_Y     = 2'd1,
        CFG_NORMAL_Z     = 2'd2,
        CFG_PLANE_OFFSET = 2'd3
    } t_cfg_idx;
    localparam logic signed [NW-1:0] NORMAL_Z_RESET = 16'sd16384;

    typedef logic signed [CW-1:0] t_coord;
    typedef t_coord [2:0] t_vec;                  // 0 = x, 1 = y, 2 = z
    typedef logic signed [DW-1:0] t_dist;

    // How a triangle is split
    typedef enum logic [1:0] {
        K_WHOLE_ABOVE = 2'd0,
        K_WHOLE_BELOW = 2'd1,
        K_LONE_BELOW  = 2'd2,
        K_LONE_ABOVE  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_vec  s;       // lone vertex, or v0 for a whole triangle
        t_vec  p;
        t_vec  q;
    } t_item;

    typedef struct packed {
        logic signed [FW-1:0] v0_x;
        logic signed [FW-1:0] v0_y;
        logic signed [FW-1:0] v0_z;
        logic signed [FW-1:0] v1_x;
        logic signed [FW-1:0] v1_y;
        logic signed [FW-1:0] v1_z;
        logic signed [FW-1:0] v2_x;
        logic signed [FW-1:0] v2_y;
        logic signed [FW-1:0] v2_z;
    } t_tri;

    typedef struct packed {
        logic                 side;
        logic signed [FW-1:0] out_a_x;
        logic signed [FW-1:0] out_a_y;
        logic signed [FW-1:0] out_a_z;
        logic signed [FW-1:0] out_b_x;
        logic signed [FW-1:0] out_b_y;
        logic signed [FW-1:0] out_b_z;
        logic signed [FW-1:0] out_c_x;
        logic signed [FW-1:0] out_c_y;
        logic signed [FW-1:0] out_c_z;
        logic                 last_of_triangle;
    } t_res;

    // Build one result triangle, sign-extending coordinates to field width
    function automatic t_res make_res(logic side, t_vec a, t_vec b, t_vec c,
                                      logic last);
        t_res r;
        r.side = side;
        r.out_a_x = FW'(a[0]);
        r.out_a_y = FW'(a[1]);
        r.out_a_z = FW'(a[2]);
        r.out_b_x = FW'(b[0]);
        r.out_b_y = FW'(b[1]);
        r.out_b_z = FW'(b[2]);
        r.out_c_x = FW'(c[0]);
        r.out_c_y = FW'(c[1]);
        r.out_c_z = FW'(c[2]);
        r.last_of_triangle = last;
        return r;
    endfunction

endpackage

FILE: rtl/tcpc_ifs.sv
// Valid/ready channel interfaces for triangles in and result triangles out.
// Depends on tcpc_pkg for the payload structs.
interface tcpc_tri_if import tcpc_pkg::*; ();
    logic valid;
    logic ready;
    t_tri data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcpc_res_if import tcpc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/tcpc_dist.sv
// Signed plane distance lane for one vertex: d = n.v - w, two stages.
// Depends on tcpc_pkg.
module tcpc_dist import tcpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_vec                  i_v,
    input  logic signed [NW-1:0]  i_nx,
    input  logic signed [NW-1:0]  i_ny,
    input  logic signed [NW-1:0]  i_nz,
    input  logic signed [FW-1:0]  i_w,
    output t_dist                 o_d,
    output logic                  o_frac_zero
);

    logic signed [PW-1:0] r_p [3];
    logic signed [SW-1:0] w_sum;
    t_dist                n_d;
    t_dist                r_d;
    logic                 r_fz;

    // Products of normal and coordinate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= PW'(i_nx) * PW'(i_v[0]);
            r_p[1] <= PW'(i_ny) * PW'(i_v[1]);
            r_p[2] <= PW'(i_nz) * PW'(i_v[2]);
        end
    end

    // Sum, floor to Q.16, subtract the offset
    always_comb begin
        w_sum = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]);
        n_d = DW'(w_sum >>> FRAC_DROP) - DW'(i_w);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d  <= n_d;
            r_fz <= (w_sum[FRAC_DROP-1:0] == '0);
        end
    end

    assign o_d = r_d;
    assign o_frac_zero = r_fz;

endmodule

FILE: rtl/tcpc_cut.sv
// Edge cut lane for one coordinate: I = S + round(|E-S|*|dS|/|dS-dE|) * sign.
// Multiplier in two slices, then a one-bit-per-stage restoring divider.
// Depends on tcpc_pkg.
module tcpc_cut import tcpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_coord  i_s,
    input  t_coord  i_e,
    input  t_dist   i_ds,
    input  t_dist   i_de,
    output t_coord  o_i
);

    // Stage 0: magnitudes and signs
    logic signed [CW:0]   w_diff;
    logic signed [DW:0]   w_dd;
    logic [CW-1:0]        r0_m;
    logic [DW-1:0]        r0_num;
    logic [RW-1:0]        r0_den;
    logic                 r0_neg;
    t_coord               r0_s;

    always_comb begin
        w_diff = (CW+1)'(i_e) - (CW+1)'(i_s);
        w_dd   = (DW+1)'(i_ds) - (DW+1)'(i_de);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_m   <= w_diff[CW] ? CW'(-w_diff) : CW'(w_diff);
            r0_num <= i_ds[DW-1] ? DW'(-i_ds) : DW'(i_ds);
            r0_den <= w_dd[DW] ? RW'(-w_dd) : RW'(w_dd);
            r0_neg <= w_diff[CW];
            r0_s   <= i_s;
        end
    end

    // Stage 1: partial products
    logic [CW+NLO-1:0] r1_plo;
    logic [CW+NHI-1:0] r1_phi;
    logic [RW-1:0]     r1_den;
    logic              r1_neg;
    t_coord            r1_s;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_plo <= (CW+NLO)'(r0_m) * (CW+NLO)'(r0_num[NLO-1:0]);
            r1_phi <= (CW+NHI)'(r0_m) * (CW+NHI)'(r0_num[DW-1:NLO]);
            r1_den <= r0_den;
            r1_neg <= r0_neg;
            r1_s   <= r0_s;
        end
    end

    // Stage 2: dividend; divider stage 0 state
    logic [XW-1:0]  w_x;
    logic [RW-1:0]  r_rem [CW+1];
    logic [CW-1:0]  r_lo  [CW+1];
    logic [CW-1:0]  r_quo [CW+1];
    logic [RW-1:0]  r_den [CW+1];
    logic           r_neg [CW+1];
    t_coord         r_s   [CW+1];

    assign w_x = XW'(r1_plo) + (XW'(r1_phi) << NLO);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(w_x[XW-1:CW]);
            r_lo[0]  <= w_x[CW-1:0];
            r_quo[0] <= '0;
            r_den[0] <= r1_den;
            r_neg[0] <= r1_neg;
            r_s[0]   <= r1_s;
        end
    end

    // Divider stages: one quotient bit each, most significant first
    logic [RW:0]    w_t   [CW+1];
    logic           w_ge  [CW+1];
    logic [RW-1:0]  n_rem [CW+1];
    logic [CW-1:0]  n_quo [CW+1];

    always_comb begin
        w_t[0]   = '0;
        w_ge[0]  = 1'b0;
        n_rem[0] = '0;
        n_quo[0] = '0;
        for (int j = 1; j <= CW; j++) begin
            w_t[j]   = {r_rem[j-1], r_lo[j-1][CW-j]};
            w_ge[j]  = (w_t[j] >= {1'b0, r_den[j-1]});
            n_rem[j] = w_ge[j] ? RW'(w_t[j] - {1'b0, r_den[j-1]}) : w_t[j][RW-1:0];
            n_quo[j] = r_quo[j-1];
            n_quo[j][CW-j] = w_ge[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 1; j <= CW; j++) begin
                r_rem[j] <= n_rem[j];
                r_lo[j]  <= r_lo[j-1];
                r_quo[j] <= n_quo[j];
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_s[j]   <= r_s[j-1];
            end
        end
    end

    // Round half up on the magnitude, apply direction, saturate
    logic                w_rnd;
    logic [CW:0]         w_q1;
    logic signed [CW+1:0] w_sum;
    t_coord              n_i;
    t_coord              r_i;

    always_comb begin
        w_rnd = ({r_rem[CW], 1'b0} >= {1'b0, r_den[CW]});
        w_q1  = {1'b0, r_quo[CW]} + (CW+1)'(w_rnd);
        w_sum = r_neg[CW] ? ((CW+2)'(r_s[CW]) - $signed({1'b0, w_q1}))
                          : ((CW+2)'(r_s[CW]) + $signed({1'b0, w_q1}));
        if (w_sum > $signed({3'b000, {(CW-1){1'b1}}}))
            n_i = {1'b0, {(CW-1){1'b1}}};
        else if (w_sum < $signed({3'b111, {(CW-1){1'b0}}}))
            n_i = {1'b1, {(CW-1){1'b0}}};
        else
            n_i = w_sum[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_i <= n_i;
        end
    end

    assign o_i = r_i;

endmodule

FILE: rtl/tcpc_merge.sv
// Merging stage: takes one finished triangle with its two cuts and hands out
// its one or three result triangles through a registered output.
// Depends on tcpc_pkg and tcpc_ifs.
module tcpc_merge import tcpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_item              i_item,
    input  t_vec               i_i1,
    input  t_vec               i_i2,
    output logic               o_take,
    tcpc_res_if.source         o_res
);

    logic        r_slot_v;
    t_item       r_item;
    t_vec        r_i1;
    t_vec        r_i2;
    logic [1:0]  r_cnt;
    logic        r_out_v;
    t_res        r_out;

    logic        w_out_free;
    logic        w_emit;
    t_res        w_res;

    // Pick the result triangle for the current count
    always_comb begin
        case (r_item.kind)
            K_WHOLE_ABOVE: w_res = make_res(1'b0, r_item.s, r_item.p, r_item.q, 1'b1);
            K_WHOLE_BELOW: w_res = make_res(1'b1, r_item.s, r_item.p, r_item.q, 1'b1);
            K_LONE_BELOW: begin
                case (r_cnt)
                    2'd0:    w_res = make_res(1'b0, r_item.p, r_i1, r_i2, 1'b0);
                    2'd1:    w_res = make_res(1'b0, r_item.p, r_i2, r_item.q, 1'b0);
                    default: w_res = make_res(1'b1, r_item.s, r_i1, r_i2, 1'b1);
                endcase
            end
            K_LONE_ABOVE: begin
                case (r_cnt)
                    2'd0:    w_res = make_res(1'b0, r_item.s, r_i1, r_i2, 1'b0);
                    2'd1:    w_res = make_res(1'b1, r_item.p, r_i1, r_i2, 1'b0);
                    default: w_res = make_res(1'b1, r_item.p, r_i2, r_item.q, 1'b1);
                endcase
            end
            default: w_res = make_res(1'b0, r_item.s, r_item.p, r_item.q, 1'b1);
        endcase
    end

    assign w_out_free = !r_out_v || o_res.ready;
    assign w_emit     = r_slot_v && w_out_free;
    assign o_take     = !r_slot_v || (w_emit && w_res.last_of_triangle);

    // Hold the triangle until its last result has gone out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_v <= 1'b0;
            r_cnt    <= 2'd0;
        end else if (o_take) begin
            r_slot_v <= i_valid;
            r_cnt    <= 2'd0;
        end else if (w_emit) begin
            r_cnt    <= r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= i_item;
            r_i1   <= i_i1;
            r_i2   <= i_i2;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_emit) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

endmodule

FILE: rtl/triangle_plane_clipper_core.sv
// Triangle plane clipper, top level: config registers, distance and cut lanes.
// Depends on tcpc_pkg, tcpc_ifs, tcpc_dist, tcpc_cut and tcpc_merge.
//
// Splits each triangle against the plane n.v = w. A triangle wholly on one
// side gives one result; a triangle crossing the plane gives three, above-side
// ones first, the last one flagged. The pipeline takes a new triangle every
// cycle while the result side keeps up; the single result port then sets the
// pace: one transfer per whole triangle, three per split one. Most of the
// pipeline depth lies in the bit-per-stage divider of each of the six cut lanes
// (one per coordinate and edge). When the merging stage cannot take the tail
// triangle the whole pipeline holds. Write the plane registers only while idle.
module triangle_plane_clipper_core import tcpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    tcpc_tri_if.sink              i_tri,
    tcpc_res_if.source            o_res
);

    // Plane registers
    logic signed [NW-1:0] r_nx;
    logic signed [NW-1:0] r_ny;
    logic signed [NW-1:0] r_nz;
    logic signed [FW-1:0] r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= '0;
            r_ny <= '0;
            r_nz <= NORMAL_Z_RESET;
            r_w  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NORMAL_X:     r_nx <= i_cfg_data[NW-1:0];
                CFG_NORMAL_Y:     r_ny <= i_cfg_data[NW-1:0];
                CFG_NORMAL_Z:     r_nz <= i_cfg_data[NW-1:0];
                CFG_PLANE_OFFSET: r_w  <= i_cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advance: the whole datapath holds when the tail cannot drain
    logic w_en;
    logic w_take;
    logic r_lv [L_CUT];

    assign w_en = !r_lv[L_CUT-1] || w_take;
    assign i_tri.ready = w_en;

    // Input vertices, low coordinate bits
    t_vec w_vin [3];
    always_comb begin
        w_vin[0] = {CW'(i_tri.data.v0_z), CW'(i_tri.data.v0_y), CW'(i_tri.data.v0_x)};
        w_vin[1] = {CW'(i_tri.data.v1_z), CW'(i_tri.data.v1_y), CW'(i_tri.data.v1_x)};
        w_vin[2] = {CW'(i_tri.data.v2_z), CW'(i_tri.data.v2_y), CW'(i_tri.data.v2_x)};
    end

    // Stages 1 and 2: carry vertices alongside the distance lanes
    logic  r_v1;
    logic  r_v2;
    t_vec  r_vtx1 [3];
    t_vec  r_vtx2 [3];
    t_dist w_d  [3];
    logic  w_fz [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_tri.valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vtx1 <= w_vin;
            r_vtx2 <= r_vtx1;
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_dist
        tcpc_dist u_dist (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_v         (w_vin[g]),
            .i_nx        (r_nx),
            .i_ny        (r_ny),
            .i_nz        (r_nz),
            .i_w         (r_w),
            .o_d         (w_d[g]),
            .o_frac_zero (w_fz[g])
        );
    end

    // Classify vertices and pick the lone one
    logic [2:0] w_ge;
    logic [2:0] w_le;
    logic [1:0] w_cnt;
    logic [1:0] w_lone;
    logic [1:0] w_pi;
    logic [1:0] w_qi;
    t_kind      w_kind;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ge[i] = !w_d[i][DW-1];
            w_le[i] = w_d[i][DW-1] || ((w_d[i] == '0) && w_fz[i]);
        end
        w_cnt = 2'(w_ge[0]) + 2'(w_ge[1]) + 2'(w_ge[2]);
        w_lone = 2'd0;
        if (w_ge == 3'b111) begin
            w_kind = K_WHOLE_ABOVE;
        end else if (w_le == 3'b111) begin
            w_kind = K_WHOLE_BELOW;
        end else begin
            w_kind = (w_cnt == 2'd2) ? K_LONE_BELOW : K_LONE_ABOVE;
            for (int i = 0; i < 3; i++) begin
                if ((w_cnt == 2'd2) ? !w_ge[i] : w_ge[i])
                    w_lone = 2'(i);
            end
        end
        w_pi = (w_lone == 2'd0) ? 2'd1 : 2'd0;
        w_qi = (w_lone == 2'd2) ? 2'd1 : 2'd2;
    end

    // Stage 3: ordered vertices and their distances
    logic  r_v3;
    t_item r_item3;
    t_dist r_ds3;
    t_dist r_dp3;
    t_dist r_dq3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_item3.kind <= w_kind;
            r_item3.s    <= r_vtx2[w_lone];
            r_item3.p    <= r_vtx2[w_pi];
            r_item3.q    <= r_vtx2[w_qi];
            r_ds3        <= w_d[w_lone];
            r_dp3        <= w_d[w_pi];
            r_dq3        <= w_d[w_qi];
        end
    end

    // Cut lanes: one per coordinate on each of the edges s-p and s-q
    t_vec w_i1;
    t_vec w_i2;

    for (genvar k = 0; k < 3; k++) begin : g_cut
        tcpc_cut u_cut1 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_s   (r_item3.s[k]),
            .i_e   (r_item3.p[k]),
            .i_ds  (r_ds3),
            .i_de  (r_dp3),
            .o_i   (w_i1[k])
        );
        tcpc_cut u_cut2 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_s   (r_item3.s[k]),
            .i_e   (r_item3.q[k]),
            .i_ds  (r_ds3),
            .i_de  (r_dq3),
            .o_i   (w_i2[k])
        );
    end

    // Delay line matching the cut lanes
    t_item r_line [L_CUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < L_CUT; j++)
                r_lv[j] <= 1'b0;
        end else if (w_en) begin
            r_lv[0] <= r_v3;
            for (int j = 1; j < L_CUT; j++)
                r_lv[j] <= r_lv[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_line[0] <= r_item3;
            for (int j = 1; j < L_CUT; j++)
                r_line[j] <= r_line[j-1];
        end
    end

    tcpc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_lv[L_CUT-1]),
        .i_item  (r_line[L_CUT-1]),
        .i_i1    (w_i1),
        .i_i2    (w_i2),
        .o_take  (w_take),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/tcpc_checker.sv
// Port-level checks on the result channel of the triangle plane clipper.
// Depends on tcpc_pkg; bound to triangle_plane_clipper_core below.
module tcpc_result_checks import tcpc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    // Stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // Stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    // Reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // The rest of a split triangle follows without a gap
    a_split_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_of_triangle |=> i_out_valid)
        else $error("gap inside a split triangle");

endmodule

bind triangle_plane_clipper_core tcpc_result_checks u_tcpc_result_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

FILE: tb/tcpc_checker.sv
// Scoreboard for the triangle plane clipper: tracks the plane registers, predicts
// the result triangles of each input transaction and compares them in order.
// Depends on tcpc_pkg and the channel interfaces in tcpc_ifs.
`timescale 1ns / 100ps
module tcpc_checker import tcpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tcpc_tri_if                  tri_mon,
    tcpc_res_if                  res_mon,
    output int                   o_fail_cnt,
    output int                   o_pending,
    output int                   o_split_cnt,
    output int                   o_res_cnt
);

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_pt;

    logic signed [15:0] plane_nx, plane_ny, plane_nz;
    logic signed [31:0] plane_w;
    t_res               expected_tris[$];

    // Signed distance of a point to the plane: floor in Q.16, plus the dropped fraction
    task automatic plane_distance(input t_pt v, output logic signed [63:0] d16,
                                  output logic [13:0] frac);
        logic signed [63:0] acc;
        acc = 64'(plane_nx) * v.x + 64'(plane_ny) * v.y + 64'(plane_nz) * v.z;
        d16 = (acc >>> 14) - 64'(plane_w);
        frac = acc[13:0];
    endtask

    // One coordinate of the cut on edge s->e, rounded half away from zero
    function automatic logic signed [63:0] edge_cut(logic signed [63:0] s,
            logic signed [63:0] e, logic signed [63:0] ds, logic signed [63:0] de);
        logic signed [63:0] diff, dd;
        logic [63:0]        mag, num, den;
        logic [127:0]       prod, quo, rem;
        diff = e - s;
        dd = ds - de;
        mag = (diff < 0) ? -diff : diff;
        num = (ds < 0) ? -ds : ds;
        den = (dd < 0) ? -dd : dd;
        if (den == 0) return s;
        prod = 128'(mag) * 128'(num);
        quo = prod / 128'(den);
        rem = prod % 128'(den);
        if (rem >= 128'(den) - rem) quo = quo + 1;
        return (diff < 0) ? s - $signed(quo[63:0]) : s + $signed(quo[63:0]);
    endfunction

    function automatic t_pt cut_point(t_pt s, t_pt e, logic signed [63:0] ds,
                                      logic signed [63:0] de);
        t_pt o;
        o.x = edge_cut(s.x, e.x, ds, de);
        o.y = edge_cut(s.y, e.y, ds, de);
        o.z = edge_cut(s.z, e.z, ds, de);
        return o;
    endfunction

    function automatic t_res out_tri(logic side, t_pt a, t_pt b, t_pt c, logic last);
        t_res r;
        r.side = side;
        r.out_a_x = a.x[31:0];
        r.out_a_y = a.y[31:0];
        r.out_a_z = a.z[31:0];
        r.out_b_x = b.x[31:0];
        r.out_b_y = b.y[31:0];
        r.out_b_z = b.z[31:0];
        r.out_c_x = c.x[31:0];
        r.out_c_y = c.y[31:0];
        r.out_c_z = c.z[31:0];
        r.last_of_triangle = last;
        return r;
    endfunction

    // Classify the triangle and queue the result triangles it splits into
    task automatic split_triangle(input t_tri t);
        t_pt                v[3];
        t_pt                c1, c2;
        logic signed [63:0] d[3];
        logic [13:0]        fr[3];
        logic               ge[3], le[3];
        int                 n_ge, lone, pa, pb;
        v[0] = '{64'(t.v0_x), 64'(t.v0_y), 64'(t.v0_z)};
        v[1] = '{64'(t.v1_x), 64'(t.v1_y), 64'(t.v1_z)};
        v[2] = '{64'(t.v2_x), 64'(t.v2_y), 64'(t.v2_z)};
        n_ge = 0;
        lone = 0;
        for (int i = 0; i < 3; i++) begin
            plane_distance(v[i], d[i], fr[i]);
            ge[i] = (d[i] >= 0);
            le[i] = (d[i] < 0) || (d[i] == 0 && fr[i] == 0);
            if (ge[i]) n_ge++;
        end
        if (n_ge == 3) begin
            expected_tris.push_back(out_tri(1'b0, v[0], v[1], v[2], 1'b1));
        end else if (le[0] && le[1] && le[2]) begin
            expected_tris.push_back(out_tri(1'b1, v[0], v[1], v[2], 1'b1));
        end else begin
            o_split_cnt++;
            for (int i = 0; i < 3; i++)
                if ((n_ge == 2) ? !ge[i] : ge[i]) lone = i;
            pa = (lone == 0) ? 1 : 0;
            pb = (lone == 2) ? 1 : 2;
            c1 = cut_point(v[lone], v[pa], d[lone], d[pa]);
            c2 = cut_point(v[lone], v[pb], d[lone], d[pb]);
            if (n_ge == 2) begin
                expected_tris.push_back(out_tri(1'b0, v[pa], c1, c2, 1'b0));
                expected_tris.push_back(out_tri(1'b0, v[pa], c2, v[pb], 1'b0));
                expected_tris.push_back(out_tri(1'b1, v[lone], c1, c2, 1'b1));
            end else begin
                expected_tris.push_back(out_tri(1'b0, v[lone], c1, c2, 1'b0));
                expected_tris.push_back(out_tri(1'b1, v[pa], c1, c2, 1'b0));
                expected_tris.push_back(out_tri(1'b1, v[pa], c2, v[pb], 1'b1));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic compare_result(input t_res act);
        t_res ex;
        if (expected_tris.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, act);
            o_fail_cnt++;
            return;
        end
        ex = expected_tris.pop_front();
        check_field("side", 32'(ex.side), 32'(act.side));
        check_field("out_a_x", ex.out_a_x, act.out_a_x);
        check_field("out_a_y", ex.out_a_y, act.out_a_y);
        check_field("out_a_z", ex.out_a_z, act.out_a_z);
        check_field("out_b_x", ex.out_b_x, act.out_b_x);
        check_field("out_b_y", ex.out_b_y, act.out_b_y);
        check_field("out_b_z", ex.out_b_z, act.out_b_z);
        check_field("out_c_x", ex.out_c_x, act.out_c_x);
        check_field("out_c_y", ex.out_c_y, act.out_c_y);
        check_field("out_c_z", ex.out_c_z, act.out_c_z);
        check_field("last_of_triangle", 32'(ex.last_of_triangle),
                    32'(act.last_of_triangle));
    endtask

    initial begin
        o_fail_cnt = 0;
        o_split_cnt = 0;
        o_res_cnt = 0;
    end

    // Track registers, predict on input transactions, check result transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plane_nx <= '0;
            plane_ny <= '0;
            plane_nz <= NORMAL_Z_RESET;
            plane_w <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_NORMAL_X:     plane_nx <= i_cfg_data[15:0];
                    CFG_NORMAL_Y:     plane_ny <= i_cfg_data[15:0];
                    CFG_NORMAL_Z:     plane_nz <= i_cfg_data[15:0];
                    CFG_PLANE_OFFSET: plane_w <= i_cfg_data;
                    default: ;
                endcase
            end
            if (tri_mon.valid && tri_mon.ready) split_triangle(tri_mon.data);
            if (res_mon.valid && res_mon.ready) begin
                o_res_cnt++;
                compare_result(res_mon.data);
            end
        end
        o_pending <= expected_tris.size();
    end

endmodule

FILE: tb/tb_top.sv
// Testbench top for triangle_plane_clipper_core: clock, reset, register writes,
// triangle stimulus, result-side back-pressure and the final verdict.
// Depends on tcpc_pkg, tcpc_ifs, the block itself and tcpc_checker.
`timescale 1ns / 100ps
module tb_top;
    import tcpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    int                   fail_cnt, pending, split_cnt, res_cnt;
    int                   sent_cnt, cycle_cnt;
    logic                 steady_send, steady_recv, hold_done;

    tcpc_tri_if tri_ch ();
    tcpc_res_if res_ch ();

    triangle_plane_clipper_core DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tri     (tri_ch),
        .o_res     (res_ch)
    );

    tcpc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .tri_mon    (tri_ch),
        .res_mon    (res_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_split_cnt(split_cnt),
        .o_res_cnt  (res_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hung run
    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off once the pipe is busy
    initial begin
        res_ch.ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_cnt >= 95) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
            end
            res_ch.ready <= steady_recv ? 1'b1 : ($urandom_range(0, 99) >= 38);
        end
    end

    // Drive one register write for a cycle; the caller drops the enable
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic set_plane(input logic [15:0] nx, input logic [15:0] ny,
                             input logic [15:0] nz, input logic [31:0] w);
        write_reg(CFG_NORMAL_X, {{16{nx[15]}}, nx});
        write_reg(CFG_NORMAL_Y, {{16{ny[15]}}, ny});
        write_reg(CFG_NORMAL_Z, {{16{nz[15]}}, nz});
        write_reg(CFG_PLANE_OFFSET, w);
        i_cfg_we <= 1'b0;
    endtask

    task automatic valid_low();
        tri_ch.valid <= 1'b0;
    endtask

    // Wait until every expected result has come back and the pipe is empty
    task automatic drain();
        valid_low();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Offer one triangle and hold it until the block takes it
    task automatic send_tri(input t_tri t);
        while (!steady_send && $urandom_range(0, 99) < 38) begin
            tri_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data <= t;
        do @(posedge i_clk); while (!tri_ch.ready);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Mostly small coordinates around the plane, sometimes the full range
    function automatic logic [31:0] rand_coord(int full);
        if (full != 0) return $urandom;
        return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   full;
        full = ($urandom_range(0, 3) == 0);
        t = {rand_coord(full), rand_coord(full), rand_coord(full),
             rand_coord(full), rand_coord(full), rand_coord(full),
             rand_coord(full), rand_coord(full), rand_coord(full)};
        return t;
    endfunction

    function automatic t_tri mk_tri(logic [31:0] z0, logic [31:0] z1, logic [31:0] z2);
        t_tri t;
        t = {32'h0001_0000, 32'hFFFE_8000, z0,
             32'h7FFF_FFFF, 32'h8000_0000, z1,
             32'h8000_0000, 32'h7FFF_FFFF, z2};
        return t;
    endfunction

    task automatic random_burst(input int n);
        for (int k = 0; k < n; k++) begin
            steady_send = (k >= n / 2 && k < n / 2 + 8);
            send_tri(rand_tri());
        end
        steady_send = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tri_ch.valid = 1'b0;
        tri_ch.data = '0;
        sent_cnt = 0;
        steady_send = 1'b0;
        steady_recv = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed cases at the reset plane z = 0: whole sides, each lone vertex
        send_tri(mk_tri(32'h0001_0000, 32'h0002_0000, 32'h0000_8000));
        send_tri(mk_tri(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_FFFF));
        send_tri(mk_tri(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000));
        send_tri(mk_tri(32'h0002_0000, 32'hFFFF_0000, 32'h0003_0000));
        send_tri(mk_tri(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000));
        send_tri(mk_tri(32'h0001_0000, 32'hFFFE_0000, 32'hFFFD_0000));
        send_tri(mk_tri(32'hFFFE_0000, 32'h0001_0000, 32'hFFFD_0000));
        send_tri(mk_tri(32'hFFFE_0000, 32'hFFFD_0000, 32'h0001_0000));
        // vertex on the plane inside a mixed triangle, and all on the plane
        send_tri(mk_tri(32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000));
        send_tri(mk_tri(32'h0000_0000, 32'hFFFF_0000, 32'hFFFE_0000));
        send_tri(mk_tri(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        // extreme coordinates, cut across the full range
        send_tri(mk_tri(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_tri(mk_tri(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_tri(mk_tri(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
        send_tri({9{32'hFFFF_FFFF}});
        send_tri({9{32'h5555_AAAA}});
        drain();

        // Fractional normal so tiny positive distances land in the dropped bits
        set_plane(16'h0001, 16'hFFFD, 16'h0003, 32'h0000_0000);
        random_burst(20);
        drain();

        // Extreme normals and offsets
        set_plane(16'h7FFF, 16'h8000, 16'h0000, 32'h7FFF_FFFF);
        random_burst(8);
        drain();
        set_plane(16'h8000, 16'h7FFF, 16'h8000, 32'h8000_0000);
        random_burst(8);
        drain();

        // Tilted random plane, long steady stretch on both sides, then pressure
        set_plane(16'($urandom), 16'($urandom), 16'($urandom), $urandom_range(0, 32'h1_0000));
        steady_recv = 1'b1;
        random_burst(20);
        steady_recv = 1'b0;
        random_burst(60);
        drain();

        $display("Covered %0d triangles (%0d split) and %0d result triangles", sent_cnt,
                 split_cnt, res_cnt);
        $display("over five plane settings, including extreme normals and offsets.");
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tcpc_pkg.sv
rtl/tcpc_ifs.sv
rtl/tcpc_dist.sv
rtl/tcpc_cut.sv
rtl/tcpc_merge.sv
rtl/triangle_plane_clipper_core.sv
rtl/tcpc_checker.sv
tb/tcpc_checker.sv
tb/tb_top.sv
